// ----- hdl/mrf_pkg.sv -----
// shared types, codes and crc helper for the modbus rtu request framer
package mrf_pkg;

  // operation codes on the command channel
  typedef enum logic [2:0] {
    OP_READ_COIL     = 3'd0,
    OP_READ_DISCRETE = 3'd1,
    OP_READ_HOLDING  = 3'd2,
    OP_READ_INPUT    = 3'd3,
    OP_WRITE_COIL    = 3'd4,
    OP_WRITE_REG     = 3'd5,
    OP_LOOPBACK      = 3'd6,
    OP_UNUSED        = 3'd7
  } op_e;

  // modbus function codes
  localparam logic [7:0] FC_READ_COIL     = 8'h01;
  localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT    = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
  localparam logic [7:0] FC_WRITE_REG     = 8'h06;
  localparam logic [7:0] FC_LOOPBACK      = 8'h08;

  // data words
  localparam logic [15:0] READ_COUNT = 16'h0001;
  localparam logic [15:0] COIL_ON    = 16'hFF00;
  localparam logic [15:0] COIL_OFF   = 16'h0000;

  // crc-16 parameters
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // frame layout
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned HDR_LEN   = 6;
  localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(HDR_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  // register map
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic [7:0] SLAVE_ADDRESS_RST = 8'h01;

  // the six header bytes, byte 0 in the top bits
  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  fcode;
    logic [15:0] addr;
    logic [15:0] data;
  } frame_hdr_t;

  // one byte step of the reflected crc
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/mrf_header.sv -----
// command register: takes a command and builds the six header bytes
module mrf_header (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         slave_address_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [15:0]        object_number_i,
  input  logic [15:0]        write_value_i,
  output logic               hdr_valid_o,
  input  logic               hdr_ready_i,
  output mrf_pkg::frame_hdr_t hdr_o
);

  logic                hdr_valid_q, hdr_valid_d;
  mrf_pkg::frame_hdr_t hdr_q, hdr_d;
  logic                in_xfer;
  mrf_pkg::op_e        op;

  assign op         = mrf_pkg::op_e'(func_i);
  assign in_ready_o = !hdr_valid_q || hdr_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // header build from the incoming command
  always_comb begin
    hdr_d.slave = slave_address_i;
    hdr_d.addr  = object_number_i - 16'd1;
    hdr_d.fcode = mrf_pkg::FC_READ_COIL;
    hdr_d.data  = mrf_pkg::READ_COUNT;
    unique case (op)
      mrf_pkg::OP_READ_COIL:     hdr_d.fcode = mrf_pkg::FC_READ_COIL;
      mrf_pkg::OP_READ_DISCRETE: hdr_d.fcode = mrf_pkg::FC_READ_DISCRETE;
      mrf_pkg::OP_READ_HOLDING:  hdr_d.fcode = mrf_pkg::FC_READ_HOLDING;
      mrf_pkg::OP_READ_INPUT:    hdr_d.fcode = mrf_pkg::FC_READ_INPUT;
      mrf_pkg::OP_WRITE_COIL: begin
        hdr_d.fcode = mrf_pkg::FC_WRITE_COIL;
        hdr_d.data  = (write_value_i != 16'd0) ? mrf_pkg::COIL_ON : mrf_pkg::COIL_OFF;
      end
      mrf_pkg::OP_WRITE_REG: begin
        hdr_d.fcode = mrf_pkg::FC_WRITE_REG;
        hdr_d.data  = write_value_i;
      end
      mrf_pkg::OP_LOOPBACK: begin
        hdr_d.fcode = mrf_pkg::FC_LOOPBACK;
        hdr_d.addr  = 16'd0;
        hdr_d.data  = 16'd0;
      end
      default: hdr_d.fcode = mrf_pkg::FC_READ_COIL;
    endcase
  end

  // valid tracking, unused operation is dropped on transfer
  always_comb begin
    hdr_valid_d = hdr_valid_q;
    if (in_xfer) begin
      hdr_valid_d = (op != mrf_pkg::OP_UNUSED);
    end else if (hdr_ready_i) begin
      hdr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_valid_q <= 1'b0;
    end else begin
      hdr_valid_q <= hdr_valid_d;
    end
  end

  // header payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hdr_q <= hdr_d;
    end
  end

  assign hdr_valid_o = hdr_valid_q;
  assign hdr_o       = hdr_q;

`ifndef SYNTHESIS
  // an unused operation never reaches the serializer
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op == mrf_pkg::OP_UNUSED) |=> !hdr_valid_q)
    else $error("unused operation produced a header");

  // a taken header that is not refilled leaves the register empty
  a_hdr_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_valid_q && hdr_ready_i && !in_valid_i) |=> !hdr_valid_q)
    else $error("header register did not drain");
`endif

endmodule

// ----- hdl/mrf_serializer.sv -----
// frame serializer: sends header bytes then the crc, one byte per transfer
module mrf_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hdr_valid_i,
  output logic                hdr_ready_o,
  input  mrf_pkg::frame_hdr_t hdr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                last_byte_o
);

  logic                     busy_q, busy_d;
  logic [mrf_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic [47:0]              data_q, data_d;
  logic [15:0]              crc_q, crc_d;
  logic                     out_xfer, is_last, in_hdr, load;

  assign is_last     = (cnt_q == mrf_pkg::IDX_LAST);
  assign in_hdr      = (cnt_q < mrf_pkg::IDX_CRC_LO);
  assign out_xfer    = busy_q && out_ready_i;
  assign hdr_ready_o = !busy_q || (out_ready_i && is_last);
  assign load        = hdr_valid_i && hdr_ready_o;

  // next frame state
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    data_d = data_q;
    crc_d  = crc_q;
    priority if (load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      data_d = hdr_i;
      crc_d  = mrf_pkg::CRC_INIT;
    end else if (out_xfer) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      if (in_hdr) begin
        crc_d  = mrf_pkg::crc16_byte(crc_q, data_q[47:40]);
        data_d = {data_q[39:0], 8'h00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // frame payload and running crc
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    crc_q  <= crc_d;
  end

  // output byte select
  always_comb begin
    if (in_hdr) begin
      frame_byte_o = data_q[47:40];
    end else if (is_last) begin
      frame_byte_o = crc_q[15:8];
    end else begin
      frame_byte_o = crc_q[7:0];
    end
  end

  assign out_valid_o = busy_q;
  assign last_byte_o = is_last;

`ifndef SYNTHESIS
  // every non-final transfer advances the byte index by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !is_last) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("byte index did not advance");

  // a new frame always starts at byte zero
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && cnt_q == '0))
    else $error("frame did not start at byte zero");

  // the final byte with nothing waiting ends the frame
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && is_last && !hdr_valid_i) |=> !busy_q)
    else $error("serializer stayed busy after last byte");
`endif

endmodule

// ----- hdl/modbus_rtu_request_framer.sv -----
// Modbus RTU request framer top level: register port, command register, serializer
// Each accepted command yields one 8-byte request frame on the output channel,
// one byte per transfer: slave address, function code, object number minus one
// (high byte first), data word (high byte first), then the CRC-16 low and high
// bytes, with last_byte_o on the CRC high byte. The serializer sends one byte per
// cycle while out_ready_i is high, folding each header byte into the CRC as it
// is sent; the next header is loaded during the last byte so frames follow with
// no gap. Commands with func 7 are accepted and produce nothing. slave_address
// sits at APB byte address 0 and resets to 1; the user must write it only while
// no frame is in flight, and the block itself does not enforce this.
module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] object_number_i,
  input  logic [15:0] write_value_i,
  // frame byte channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  logic [7:0]          slave_q;
  logic                hdr_valid, hdr_ready;
  mrf_pkg::frame_hdr_t hdr;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == mrf_pkg::REG_SLAVE_ADDRESS);

  // slave address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= mrf_pkg::SLAVE_ADDRESS_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      slave_q <= pwdata[7:0];
    end
  end

  // register read
  assign prdata = (reg_hit && paddr[1:0] == 2'd0) ? {24'd0, slave_q} : 32'd0;

  mrf_header u_header (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .slave_address_i (slave_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .object_number_i (object_number_i),
    .write_value_i   (write_value_i),
    .hdr_valid_o     (hdr_valid),
    .hdr_ready_i     (hdr_ready),
    .hdr_o           (hdr)
  );

  mrf_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hdr_valid_i  (hdr_valid),
    .hdr_ready_o  (hdr_ready),
    .hdr_i        (hdr),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule
